// ===== hdl/cpc_pkg.sv =====
package cpc_pkg;

	localparam int ZW = 36;
	localparam int CW = 64;
	localparam int FRONT_STAGES = 2;
	localparam int SQ_STAGES = 33;
	localparam int FIN_STAGES = 3;

	localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [ZW-1:0] PI_Q29_Z    = 36'sd1686629713;
	localparam logic signed [31:0]   PI_Q29      = 32'sd1686629713;
	localparam logic signed [31:0]   HALF_PI_Q29 = 32'sd843314857;
	localparam logic signed [30:0]   INV_GAIN_Q30 = 31'sd652032874;
	localparam logic [15:0]          SNAP_RESET  = 16'd2;

	typedef enum logic [2:0] {
		ANG_CORDIC,
		ANG_ZERO,
		ANG_PI,
		ANG_POS_HALF,
		ANG_NEG_HALF
	} ang_code_t;

	typedef struct packed {
		logic      mode;
		logic      neg;
		logic      zero;
		ang_code_t code;
	} ctl_t;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] x_re;
		logic signed [31:0] x_im;
		logic signed [31:0] in_mag;
		logic signed [31:0] in_angle;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_re;
		logic signed [31:0] out_im;
		logic [31:0]        magnitude;
		logic signed [31:0] angle;
		logic [63:0]        norm_sq;
		logic               zero_input;
	} out_item_t;

	function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
		logic signed [ZW-1:0] v;
		case (i)
			0: v = 36'sh03243F6A8;
			1: v = 36'sh01DAC6705;
			2: v = 36'sh00FADBAFC;
			3: v = 36'sh007F56EA6;
			4: v = 36'sh003FEAB76;
			5: v = 36'sh001FFD55B;
			6: v = 36'sh000FFFAAA;
			7: v = 36'sh0007FFF55;
			8: v = 36'sh0003FFFEA;
			9: v = 36'sh0001FFFFD;
			10: v = 36'sh0000FFFFF;
			11: v = 36'sh00007FFFF;
			12: v = 36'sh00003FFFF;
			13: v = 36'sh00001FFFF;
			14: v = 36'sh00000FFFF;
			15: v = 36'sh000007FFF;
			16: v = 36'sh000003FFF;
			17: v = 36'sh000001FFF;
			18: v = 36'sh000000FFF;
			19: v = 36'sh0000007FF;
			20: v = 36'sh0000003FF;
			21: v = 36'sh0000001FF;
			22: v = 36'sh0000000FF;
			23: v = 36'sh00000007F;
			24: v = 36'sh00000003F;
			25: v = 36'sh00000001F;
			26: v = 36'sh00000000F;
			27: v = 36'sh000000008;
			28: v = 36'sh000000004;
			29: v = 36'sh000000002;
			30: v = 36'sh000000001;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/cpc_front.sv =====
module cpc_front (
	input  logic                            clk,
	input  cpc_pkg::in_item_t               item,
	output logic signed [cpc_pkg::CW-1:0]   x,
	output logic signed [cpc_pkg::CW-1:0]   y,
	output logic signed [cpc_pkg::ZW-1:0]   z,
	output logic [63:0]                     n,
	output cpc_pkg::ctl_t                   ctl
);
	import cpc_pkg::*;

	logic signed [31:0] re, im;
	logic [31:0] ar, ai;
	logic signed [CW-1:0] xv, yv, xp, yp;
	logic signed [ZW-1:0] zp, a;
	ctl_t cp;

	logic [63:0] sq_re_s1, sq_im_s1;
	logic signed [CW-1:0] prod_s1, x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	ctl_t ctl_s1;

	logic [63:0] n_s2;
	logic signed [CW-1:0] x_s2, y_s2;
	logic signed [ZW-1:0] z_s2;
	ctl_t ctl_s2;

	always_comb begin
		re = item.x_re;
		im = item.x_im;
		ar = re[31] ? (~re + 32'd1) : re;
		ai = im[31] ? (~im + 32'd1) : im;
		xv = {{4{re[31]}}, re, 28'b0};
		yv = {{4{im[31]}}, im, 28'b0};
		a = {{(ZW-33){item.in_angle[31]}}, item.in_angle, 1'b0};
		cp.mode = item.mode;
		cp.neg = 1'b0;
		cp.zero = 1'b0;
		cp.code = ANG_CORDIC;
		xp = xv;
		yp = yv;
		zp = '0;
		if (item.mode) begin
			// fold the angle into the CORDIC range, negate at the end
			yp = '0;
			zp = a;
			if (a > HALF_PI_Q30) begin
				zp = a - PI_Q30;
				cp.neg = 1'b1;
			end else if (a < -HALF_PI_Q30) begin
				zp = a + PI_Q30;
				cp.neg = 1'b1;
			end
		end else begin
			if (re == 32'sd0 && im == 32'sd0) begin
				cp.zero = 1'b1;
				cp.code = ANG_ZERO;
			end else if (im == 32'sd0) begin
				cp.code = (re > 32'sd0) ? ANG_ZERO : ANG_PI;
			end else if (re == 32'sd0) begin
				cp.code = (im > 32'sd0) ? ANG_POS_HALF : ANG_NEG_HALF;
			end
			// pre-rotate the left half plane by a quarter turn
			if (re < 32'sd0) begin
				if (im >= 32'sd0) begin
					xp = yv;
					yp = -xv;
					zp = HALF_PI_Q30;
				end else begin
					xp = -yv;
					yp = xv;
					zp = -HALF_PI_Q30;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_re_s1 <= ar * ar;
		sq_im_s1 <= ai * ai;
		prod_s1 <= item.in_mag * INV_GAIN_Q30;
		x_s1 <= xp;
		y_s1 <= yp;
		z_s1 <= zp;
		ctl_s1 <= cp;
	end

	always_ff @(posedge clk) begin
		n_s2 <= sq_re_s1 + sq_im_s1;
		x_s2 <= ctl_s1.mode ? prod_s1 : x_s1;
		y_s2 <= y_s1;
		z_s2 <= z_s1;
		ctl_s2 <= ctl_s1;
	end

	assign x = x_s2;
	assign y = y_s2;
	assign z = z_s2;
	assign n = n_s2;
	assign ctl = ctl_s2;

endmodule

// ===== hdl/cpc_cordic.sv =====
module cpc_cordic #(
	parameter int STAGES = 30
) (
	input  logic                            clk,
	input  logic signed [cpc_pkg::CW-1:0]   x_in,
	input  logic signed [cpc_pkg::CW-1:0]   y_in,
	input  logic signed [cpc_pkg::ZW-1:0]   z_in,
	input  cpc_pkg::ctl_t                   ctl_in,
	output logic signed [cpc_pkg::CW-1:0]   x_out,
	output logic signed [cpc_pkg::CW-1:0]   y_out,
	output logic signed [cpc_pkg::ZW-1:0]   z_out,
	output cpc_pkg::ctl_t                   ctl_out
);
	import cpc_pkg::*;

	logic signed [CW-1:0] x_s [STAGES];
	logic signed [CW-1:0] y_s [STAGES];
	logic signed [ZW-1:0] z_s [STAGES];
	ctl_t ctl_s [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic signed [ZW-1:0] ATAN = atan_q30(i);
		logic signed [CW-1:0] xp, yp, xs, ys;
		logic signed [ZW-1:0] zp;
		ctl_t cp;
		logic up;

		if (i == 0) begin : g_first
			assign xp = x_in;
			assign yp = y_in;
			assign zp = z_in;
			assign cp = ctl_in;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign cp = ctl_s[i-1];
		end

		always_comb begin
			xs = xp >>> i;
			ys = yp >>> i;
			// vectoring drives y to zero, rotation drives the residual angle to zero
			up = cp.mode ? zp[ZW-1] : (yp > 64'sd0);
		end

		always_ff @(posedge clk) begin
			if (up) begin
				x_s[i] <= xp + ys;
				y_s[i] <= yp - xs;
				z_s[i] <= zp + ATAN;
			end else begin
				x_s[i] <= xp - ys;
				y_s[i] <= yp + xs;
				z_s[i] <= zp - ATAN;
			end
			ctl_s[i] <= cp;
		end
	end

	assign x_out = x_s[STAGES-1];
	assign y_out = y_s[STAGES-1];
	assign z_out = z_s[STAGES-1];
	assign ctl_out = ctl_s[STAGES-1];

endmodule

// ===== hdl/cpc_sqrt.sv =====
module cpc_sqrt (
	input  logic        clk,
	input  logic [63:0] n_in,
	output logic [31:0] mag,
	output logic [63:0] n_out
);
	import cpc_pkg::*;

	localparam int ITER = SQ_STAGES - 1;

	logic [63:0] r_s [ITER];
	logic [63:0] rem_s [ITER];
	logic [63:0] n_s [ITER];
	logic [31:0] mag_s;
	logic [63:0] nr_s;

	for (genvar k = 0; k < ITER; k++) begin : g_iter
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] rp, remp, np, trial;

		if (k == 0) begin : g_first
			assign rp = '0;
			assign remp = n_in;
			assign np = n_in;
		end else begin : g_next
			assign rp = r_s[k-1];
			assign remp = rem_s[k-1];
			assign np = n_s[k-1];
		end

		assign trial = rp + BIT;

		always_ff @(posedge clk) begin
			if (remp >= trial) begin
				rem_s[k] <= remp - trial;
				r_s[k] <= (rp >> 1) + BIT;
			end else begin
				rem_s[k] <= remp;
				r_s[k] <= rp >> 1;
			end
			n_s[k] <= np;
		end
	end

	// round to nearest: step up when the remainder exceeds the root
	always_ff @(posedge clk) begin
		mag_s <= r_s[ITER-1][31:0] + {31'b0, (rem_s[ITER-1] > r_s[ITER-1])};
		nr_s <= n_s[ITER-1];
	end

	assign mag = mag_s;
	assign n_out = nr_s;

endmodule

// ===== hdl/cpc_delay.sv =====
module cpc_delay #(
	parameter int DEPTH = 1,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	if (DEPTH == 0) begin : g_none
		assign q = d;
	end else begin : g_line
		logic [WIDTH-1:0] dly_s [DEPTH];

		always_ff @(posedge clk) begin
			dly_s[0] <= d;
			for (int k = 1; k < DEPTH; k++) begin
				dly_s[k] <= dly_s[k-1];
			end
		end

		assign q = dly_s[DEPTH-1];
	end

endmodule

// ===== hdl/cpc_finish.sv =====
module cpc_finish #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                            clk,
	input  logic signed [cpc_pkg::CW-1:0]   x,
	input  logic signed [cpc_pkg::CW-1:0]   y,
	input  logic signed [cpc_pkg::ZW-1:0]   z,
	input  cpc_pkg::ctl_t                   ctl,
	input  logic [31:0]                     mag,
	input  logic [63:0]                     n,
	input  logic [15:0]                     snap,
	output cpc_pkg::out_item_t              result
);
	import cpc_pkg::*;

	localparam int SAT_W = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
	localparam logic signed [CW-1:0] SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
	localparam logic signed [CW-1:0] SAT_LO = -SAT_HI - 64'sd1;
	localparam logic signed [CW-1:0] HALF_LSB = 64'sd1 <<< 29;

	logic signed [ZW-1:0] zr;
	logic signed [31:0] ang;
	logic signed [CW-1:0] vx, vy;
	logic signed [31:0] sx, sy;
	logic [32:0] abs_x, abs_y;

	logic signed [CW-1:0] x_s1, y_s1;
	logic signed [31:0] ang_s1, ang_s2;
	ctl_t ctl_s1, ctl_s2;
	logic [31:0] mag_s1, mag_s2;
	logic [63:0] n_s1, n_s2;
	logic signed [31:0] re_s2, im_s2;
	out_item_t res_s3;

	always_comb begin
		zr = (z + 36'sd1) >>> 1;
		if (zr > PI_Q29_Z) begin
			zr = PI_Q29_Z;
		end else if (zr < -PI_Q29_Z) begin
			zr = -PI_Q29_Z;
		end
		case (ctl.code)
			ANG_CORDIC:   ang = zr[31:0];
			ANG_ZERO:     ang = '0;
			ANG_PI:       ang = PI_Q29;
			ANG_POS_HALF: ang = HALF_PI_Q29;
			ANG_NEG_HALF: ang = -HALF_PI_Q29;
			default:      ang = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		x_s1 <= ctl.neg ? -x : x;
		y_s1 <= ctl.neg ? -y : y;
		ang_s1 <= ang;
		ctl_s1 <= ctl;
		mag_s1 <= mag;
		n_s1 <= n;
	end

	always_comb begin
		vx = (x_s1 + HALF_LSB) >>> 30;
		vy = (y_s1 + HALF_LSB) >>> 30;
		if (vx > SAT_HI) vx = SAT_HI;
		if (vx < SAT_LO) vx = SAT_LO;
		if (vy > SAT_HI) vy = SAT_HI;
		if (vy < SAT_LO) vy = SAT_LO;
	end

	always_ff @(posedge clk) begin
		re_s2 <= vx[31:0];
		im_s2 <= vy[31:0];
		ang_s2 <= ang_s1;
		ctl_s2 <= ctl_s1;
		mag_s2 <= mag_s1;
		n_s2 <= n_s1;
	end

	always_comb begin
		abs_x = re_s2[31] ? (33'd0 - {re_s2[31], re_s2}) : {1'b0, re_s2};
		abs_y = im_s2[31] ? (33'd0 - {im_s2[31], im_s2}) : {1'b0, im_s2};
		sx = (abs_x <= {17'b0, snap}) ? 32'sd0 : re_s2;
		sy = (abs_y <= {17'b0, snap}) ? 32'sd0 : im_s2;
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.mode) begin
			res_s3.out_re <= sx;
			res_s3.out_im <= sy;
			res_s3.magnitude <= '0;
			res_s3.angle <= '0;
			res_s3.norm_sq <= '0;
			res_s3.zero_input <= 1'b0;
		end else begin
			res_s3.out_re <= '0;
			res_s3.out_im <= '0;
			res_s3.magnitude <= mag_s2;
			res_s3.angle <= ang_s2;
			res_s3.norm_sq <= n_s2;
			res_s3.zero_input <= ctl_s2.zero;
		end
	end

	assign result = res_s3;

endmodule

// ===== hdl/complex_polar_converter.sv =====
// Channel   Handshake              Payload
// input     start (busy low)       item   : mode, x_re, x_im, in_mag, in_angle
// output    done, one cycle        result : out_re, out_im, magnitude, angle,
//                                           norm_sq, zero_input
// config    APB write/read         snap_threshold at byte address 0
//
// One item per clock; busy is always low.
// The CORDIC stage chain and the 32-step square root plus its rounding stage run
// side by side between the front end and the finish stages.
// Reset clears the valid chain and sets snap_threshold to 2.
// The pipeline never stalls; each result shows for exactly one cycle.
module complex_polar_converter #(
	parameter int DATA_WIDTH = 32,
	parameter int CORDIC_STAGES = 30
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cpc_pkg::in_item_t    item,
	output logic                 done,
	output cpc_pkg::out_item_t   result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [1:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import cpc_pkg::*;

	localparam int MID = (CORDIC_STAGES > SQ_STAGES) ? CORDIC_STAGES : SQ_STAGES;
	localparam int LAT = FRONT_STAGES + MID + FIN_STAGES;
	localparam int PACK_W = 2 * CW + ZW + $bits(ctl_t);

	logic [15:0] snap_q;
	logic [LAT-1:0] vld_q;

	logic signed [CW-1:0] fx, fy, cx, cy, px, py;
	logic signed [ZW-1:0] fz, cz, pz;
	ctl_t fctl, cctl, pctl;
	logic [63:0] fn, sn, pn;
	logic [31:0] smag, pmag;

	assign busy = 1'b0;
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {16'b0, snap_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_q <= SNAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr == 2'd0) begin
			snap_q <= pwdata[15:0];
		end
	end

	// valid travels alongside the data beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	assign done = vld_q[LAT-1];

	cpc_front u_front (
		.clk (clk),
		.item(item),
		.x   (fx),
		.y   (fy),
		.z   (fz),
		.n   (fn),
		.ctl (fctl)
	);

	cpc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
		.clk    (clk),
		.x_in   (fx),
		.y_in   (fy),
		.z_in   (fz),
		.ctl_in (fctl),
		.x_out  (cx),
		.y_out  (cy),
		.z_out  (cz),
		.ctl_out(cctl)
	);

	cpc_sqrt u_sqrt (
		.clk  (clk),
		.n_in (fn),
		.mag  (smag),
		.n_out(sn)
	);

	cpc_delay #(.DEPTH(MID - CORDIC_STAGES), .WIDTH(PACK_W)) u_pad_cordic (
		.clk(clk),
		.d  ({cx, cy, cz, cctl}),
		.q  ({px, py, pz, pctl})
	);

	cpc_delay #(.DEPTH(MID - SQ_STAGES), .WIDTH(96)) u_pad_sqrt (
		.clk(clk),
		.d  ({smag, sn}),
		.q  ({pmag, pn})
	);

	cpc_finish #(.DATA_WIDTH(DATA_WIDTH)) u_finish (
		.clk   (clk),
		.x     (px),
		.y     (py),
		.z     (pz),
		.ctl   (pctl),
		.mag   (pmag),
		.n     (pn),
		.snap  (snap_q),
		.result(result)
	);

	a_zero_polar: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.zero_input |->
			result.magnitude == 32'd0 && result.angle == 32'sd0 && result.norm_sq == 64'd0)
		else $error("zero input with nonzero polar result");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.angle <= PI_Q29 && result.angle >= -PI_Q29)
		else $error("angle outside minus pi to pi");

	a_mode_split: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.out_re != 32'sd0 || result.out_im != 32'sd0) |->
			result.norm_sq == 64'd0 && result.magnitude == 32'd0 && !result.zero_input)
		else $error("rectangular and polar fields both set");

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result beat without an accepted item");

endmodule
